[rtl/core/sfd_pkg.sv]
package sfd_pkg;

  // Defaults for the top-level parameters
  localparam int LINE_DEPTH_DEF  = 65536;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed-point layout of the delay time
  localparam int TARGET_BITS  = 24;   // Q16.8 target
  localparam int TARGET_SHIFT = 16;   // Q16.8 -> Q16.24
  localparam int FRAC_BITS    = 24;
  localparam int DELAY_BITS   = 16;   // integer part of the smoothed delay
  localparam int SMOOTH_BITS  = DELAY_BITS + FRAC_BITS;

  // One-pole smoothing coefficient, round(0.0002 * 2^24)
  localparam int                    ALPHA_BITS = 12;
  localparam logic [ALPHA_BITS-1:0] ALPHA_Q24  = 12'd3355;

  localparam int GAIN_BITS  = 16;     // unsigned Q1.15
  localparam int GAIN_SHIFT = 15;

  // Configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 24;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY_TARGET  = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_UPDATE,
    ST_ADDR,
    ST_READ_A,
    ST_READ_B,
    ST_INTERP,
    ST_ROUND,
    ST_FEED,
    ST_WRITE
  } sfd_state_t;

  // Per-channel phase strobes from the sequencer
  typedef struct packed {
    logic rd_en;     // read the line at rd_addr
    logic hit;       // current read data comes from a written entry
    logic cap_a;     // capture the first tap
    logic interp;    // (b - a) * frac
    logic round_en;  // a + rounded product
    logic feed;      // read value * gain
    logic write_en;  // write line, load wet register
  } sfd_ctl_t;

endpackage

[rtl/core/sfd_in_if.sv]
interface sfd_in_if #(
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

[rtl/core/sfd_wet_if.sv]
interface sfd_wet_if #(
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_wet;
  logic signed [SAMPLE_BITS-1:0] right_wet;

  modport source (output valid, left_wet, right_wet, input ready);
  modport sink   (input valid, left_wet, right_wet, output ready);
endinterface

[rtl/core/sfd_cfg_if.sv]
interface sfd_cfg_if ();
  logic                                 valid;
  logic                                 ready;
  logic [sfd_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [sfd_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/sfd_chan.sv]
module sfd_chan #(
  parameter int LINE_DEPTH  = sfd_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  sfd_pkg::sfd_ctl_t                    ctl,
  input  logic [$clog2(LINE_DEPTH)-1:0]        rd_addr,
  input  logic [$clog2(LINE_DEPTH)-1:0]        wr_addr,
  input  logic [sfd_pkg::FRAC_BITS-1:0]        frac,
  input  logic [sfd_pkg::GAIN_BITS-1:0]        gain,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  output logic signed [SAMPLE_BITS-1:0]        wet
);

  localparam int S  = SAMPLE_BITS;
  localparam int PI = S + sfd_pkg::FRAC_BITS + 2;   // (S+1) x (FRAC+1) signed
  localparam int PF = S + sfd_pkg::GAIN_BITS + 1;   // S x (GAIN+1) signed

  logic signed [S-1:0]  mem [LINE_DEPTH];
  logic signed [S-1:0]  rdata;
  logic signed [S-1:0]  tap;
  logic signed [S-1:0]  tap_a;
  logic signed [S-1:0]  rd;
  logic signed [S-1:0]  wet_q;
  logic signed [S:0]    diff;
  logic signed [PI-1:0] prod_i;
  logic signed [PI-1:0] prod_i_rnd;
  logic signed [PF-1:0] prod_f;
  logic signed [PF-1:0] prod_f_rnd;
  logic signed [S+2:0]  fb_sum;
  logic signed [S-1:0]  fb_val;

  // Entries never written read as zero
  assign tap  = ctl.hit ? rdata : '0;
  assign diff = (S+1)'(tap) - (S+1)'(tap_a);

  // Round half up, then floor by arithmetic shift
  assign prod_i_rnd = (prod_i + (PI'(1) <<< (sfd_pkg::FRAC_BITS - 1))) >>> sfd_pkg::FRAC_BITS;
  assign prod_f_rnd = (prod_f + (PF'(1) <<< (sfd_pkg::GAIN_SHIFT - 1))) >>> sfd_pkg::GAIN_SHIFT;

  assign fb_sum = (S+3)'(sample_in) + (S+3)'(prod_f_rnd);

  always_comb begin
    if ((&fb_sum[S+2:S-1]) || !(|fb_sum[S+2:S-1])) begin
      fb_val = fb_sum[S-1:0];
    end else if (fb_sum[S+2]) begin
      fb_val = {1'b1, {(S-1){1'b0}}};
    end else begin
      fb_val = {1'b0, {(S-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.write_en) begin
      mem[wr_addr] <= fb_val;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      tap_a <= tap;
    end
    if (ctl.interp) begin
      prod_i <= PI'(diff) * PI'($signed({1'b0, frac}));
    end
    if (ctl.round_en) begin
      // result lies between the two taps, so S bits always hold it
      rd <= tap_a + S'(prod_i_rnd);
    end
    if (ctl.feed) begin
      prod_f <= PF'(rd) * PF'($signed({1'b0, gain}));
    end
    if (ctl.write_en) begin
      wet_q <= rd;
    end
  end

  assign wet = wet_q;

endmodule

[rtl/core/stereo_feedback_delay_top.sv]
// Stereo feedback delay with a smoothed fractional delay time.
// Each item steps through STEP, UPDATE, ADDR, READ_A, READ_B, INTERP, ROUND, FEED and WRITE;
// WRITE holds until the output register is free. One item at a time, each line read twice
// (two interpolation taps); a new item is accepted while a result still waits.
// Reset (rst, synchronous): config registers, smoothed delay and write position go to zero,
// lines read as zero until written (fill count, no clearing pass).
module stereo_feedback_delay_top #(
  parameter int LINE_DEPTH  = sfd_pkg::LINE_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfd_pkg::SAMPLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  sfd_in_if.sink   samples,
  sfd_wet_if.source wet,
  sfd_cfg_if.sink  cfg
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int FW = $clog2(LINE_DEPTH + 1);
  localparam int CW = (AW + 1 > sfd_pkg::DELAY_BITS) ? AW + 1 : sfd_pkg::DELAY_BITS;
  localparam int SB = sfd_pkg::SMOOTH_BITS;
  localparam int MW = SB + sfd_pkg::ALPHA_BITS + 1;
  localparam int FB = sfd_pkg::FRAC_BITS;

  sfd_pkg::sfd_state_t state, state_next;
  sfd_pkg::sfd_ctl_t   ctl;

  logic [sfd_pkg::TARGET_BITS-1:0] delay_target;
  logic [sfd_pkg::GAIN_BITS-1:0]   feedback_gain;

  logic [SB-1:0]  smoothed;
  logic [SB-1:0]  target_q;
  logic [SB-1:0]  mag;
  logic           up;
  logic [MW-1:0]  step_prod;
  logic [MW-1:0]  step_rnd;
  logic [SB-1:0]  step;

  logic [sfd_pkg::DELAY_BITS-1:0] d_int;
  logic [AW-1:0]  d_cl;
  logic [AW:0]    addr_sum;
  logic [AW-1:0]  addr_a;
  logic [AW-1:0]  addr_b;
  logic [AW-1:0]  rd_addr;
  logic [FB-1:0]  frac;
  logic [AW-1:0]  wp;
  logic [FW-1:0]  fill;
  logic           hit;

  logic signed [SAMPLE_BITS-1:0] left_s;
  logic signed [SAMPLE_BITS-1:0] right_s;

  logic accept;
  logic out_valid;
  logic write_go;

  // Entry addr was first written by write number k since reset (write k goes to (-k) mod depth); hit once k < cnt.
  function automatic logic addr_hit(input logic [AW-1:0] addr, input logic [FW-1:0] cnt);
    logic [AW:0] k;
    k = (addr == '0) ? '0 : (AW+1)'(LINE_DEPTH) - (AW+1)'(addr);
    return FW'(k) < cnt;
  endfunction

  // Configuration
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_target  <= '0;
      feedback_gain <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == sfd_pkg::REG_DELAY_TARGET) begin
        delay_target <= cfg.data[sfd_pkg::TARGET_BITS-1:0];
      end else if (cfg.index == sfd_pkg::REG_FEEDBACK_GAIN) begin
        feedback_gain <= cfg.data[sfd_pkg::GAIN_BITS-1:0];
      end
    end
  end

  // Sequencer
  assign samples.ready = (state == sfd_pkg::ST_IDLE) && !rst;
  assign accept        = samples.valid && samples.ready;
  assign write_go      = (state == sfd_pkg::ST_WRITE) && (!out_valid || wet.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.hit      = hit;
    unique case (state)
      sfd_pkg::ST_IDLE: begin
        if (accept) state_next = sfd_pkg::ST_STEP;
      end
      sfd_pkg::ST_STEP:   state_next = sfd_pkg::ST_UPDATE;
      sfd_pkg::ST_UPDATE: state_next = sfd_pkg::ST_ADDR;
      sfd_pkg::ST_ADDR:   state_next = sfd_pkg::ST_READ_A;
      sfd_pkg::ST_READ_A: begin
        ctl.rd_en  = 1'b1;
        state_next = sfd_pkg::ST_READ_B;
      end
      sfd_pkg::ST_READ_B: begin
        ctl.rd_en  = 1'b1;
        ctl.cap_a  = 1'b1;
        state_next = sfd_pkg::ST_INTERP;
      end
      sfd_pkg::ST_INTERP: begin
        ctl.interp = 1'b1;
        state_next = sfd_pkg::ST_ROUND;
      end
      sfd_pkg::ST_ROUND: begin
        ctl.round_en = 1'b1;
        state_next   = sfd_pkg::ST_FEED;
      end
      sfd_pkg::ST_FEED: begin
        ctl.feed   = 1'b1;
        state_next = sfd_pkg::ST_WRITE;
      end
      sfd_pkg::ST_WRITE: begin
        // hold until the output register is free
        if (write_go) begin
          ctl.write_en = 1'b1;
          state_next   = sfd_pkg::ST_IDLE;
        end
      end
      default: state_next = sfd_pkg::ST_IDLE;
    endcase
  end

  // Smoothing and address datapath
  assign target_q = {delay_target, {sfd_pkg::TARGET_SHIFT{1'b0}}};
  assign step_rnd = step_prod + (MW'(1) << (FB - 1));
  assign step     = SB'(step_rnd[MW-1:FB]);

  assign d_int    = smoothed[SB-1:FB];
  assign d_cl     = (CW'(d_int) >= CW'(LINE_DEPTH)) ? AW'(LINE_DEPTH - 1) : AW'(d_int);
  assign addr_sum = (AW+1)'(wp) + (AW+1)'(d_cl);
  assign rd_addr  = (state == sfd_pkg::ST_READ_B) ? addr_b : addr_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      wp       <= '0;
      fill     <= '0;
      hit      <= 1'b0;
    end else begin
      if (state == sfd_pkg::ST_UPDATE) begin
        smoothed <= up ? smoothed + step : smoothed - step;
      end
      if (state == sfd_pkg::ST_READ_A) begin
        hit <= addr_hit(addr_a, fill);
      end else if (state == sfd_pkg::ST_READ_B) begin
        hit <= addr_hit(addr_b, fill);
      end
      if (write_go) begin
        wp <= (wp == '0) ? AW'(LINE_DEPTH - 1) : wp - AW'(1);
        if (fill != FW'(LINE_DEPTH)) begin
          fill <= fill + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_s  <= samples.left_in;
      right_s <= samples.right_in;
      up      <= target_q >= smoothed;
      mag     <= (target_q >= smoothed) ? target_q - smoothed : smoothed - target_q;
    end
    if (state == sfd_pkg::ST_STEP) begin
      step_prod <= MW'(mag) * MW'(sfd_pkg::ALPHA_Q24);
    end
    if (state == sfd_pkg::ST_ADDR) begin
      frac   <= smoothed[FB-1:0];
      addr_a <= (addr_sum >= (AW+1)'(LINE_DEPTH)) ? AW'(addr_sum - (AW+1)'(LINE_DEPTH))
                                                  : AW'(addr_sum);
    end
    if (state == sfd_pkg::ST_READ_A) begin
      addr_b <= (addr_a == AW'(LINE_DEPTH - 1)) ? '0 : addr_a + AW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (write_go) begin
      out_valid <= 1'b1;
    end else if (wet.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign wet.valid = out_valid;

  sfd_chan #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_left (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wp),
    .frac      (frac),
    .gain      (feedback_gain),
    .sample_in (left_s),
    .wet       (wet.left_wet)
  );

  sfd_chan #(
    .LINE_DEPTH  (LINE_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_right (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wp),
    .frac      (frac),
    .gain      (feedback_gain),
    .sample_in (right_s),
    .wet       (wet.right_wet)
  );

endmodule
